>>> sv/i2c_reg_pkg.sv
// Package for the I2C register master: command, kind, segment and CSR index codes,
// shared widths and the front-to-back transaction type. No dependencies.
`timescale 1ns / 1ps
package i2c_reg_pkg;
   localparam int DATA_MAX_DEF = 32;
   localparam int FIFO_DEPTH = 2;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_LOAD  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_PROBE = 3'd4;

   localparam logic [1:0] K_WRITE = 2'd0;
   localparam logic [1:0] K_READ  = 2'd1;
   localparam logic [1:0] K_PROBE = 2'd2;

   localparam logic [2:0] S_ADDRW = 3'd0;
   localparam logic [2:0] S_REG   = 3'd1;
   localparam logic [2:0] S_DATA  = 3'd2;
   localparam logic [2:0] S_ADDRR = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;

   localparam logic [0:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [0:0] CSR_ACK_TIMEOUT = 1'b1;

   // Classified operation handed from the front part to the back part.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [6:0]  slave_addr;
      logic [31:0] reg_addr;
      logic [2:0]  reg_bytes;
      logic [8:0]  data_count;
      logic [7:0]  write_byte;
      logic        sda_in;
   } op_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic       ack_error;
   } rsp_type;
endpackage

>>> sv/i2c_register_master_core.sv
// I2C register master: one result transaction for every request transaction, in
// order. A request is taken in any cycle in which full is low; it passes a
// two-entry queue to the bus engine, which handles one request per clock while
// the result queue has room, and the result lands in a two-entry result queue.
// Sustained rate is one transaction per clock, set by the phase engine, while
// results are popped. The transmit buffer is a RAM of DATA_MAX bytes read one
// byte ahead of use. Depends on i2c_reg_pkg, i2c_reg_front and i2c_reg_engine.
`timescale 1ns / 1ps
module i2c_register_master_core #(
   parameter int DATA_MAX = i2c_reg_pkg::DATA_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_slave_addr,
   input  logic [31:0] req_reg_addr,
   input  logic [2:0]  req_reg_bytes,
   input  logic [5:0]  req_data_count,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_ack_error,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import i2c_reg_pkg::*;

   op_type      op;
   logic        op_valid, op_take;
   rsp_type     rsp;
   logic [15:0] half_period_ff;
   logic [7:0]  ack_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= 16'd5;
         ack_timeout_ff <= 8'd255;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_data;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   i2c_reg_front #(.DATA_MAX(DATA_MAX)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_command(req_command), .req_slave_addr(req_slave_addr),
      .req_reg_addr(req_reg_addr), .req_reg_bytes(req_reg_bytes),
      .req_data_count(req_data_count), .req_write_byte(req_write_byte),
      .req_sda_in(req_sda_in), .op_out(op), .op_valid(op_valid), .op_take(op_take)
   );

   i2c_reg_engine #(.DATA_MAX(DATA_MAX)) u_engine (
      .clock(clock), .reset(reset), .op_in(op), .op_valid(op_valid), .op_take(op_take),
      .half_period(half_period_ff), .ack_timeout(ack_timeout_ff),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_out(rsp)
   );

   assign rsp_scl_out    = rsp.scl_out;
   assign rsp_sda_out    = rsp.sda_out;
   assign rsp_read_data  = rsp.read_data;
   assign rsp_read_valid = rsp.read_valid;
   assign rsp_busy_res   = rsp.busy_res;
   assign rsp_done_res   = rsp.done_res;
   assign rsp_ack_error  = rsp.ack_error;
endmodule

>>> sv/i2c_reg_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module i2c_reg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> sv/i2c_reg_front.sv
// Front part: accepts request transactions, clamps and classifies them and
// queues them for the bus engine. Depends on i2c_reg_pkg.
`timescale 1ns / 1ps
module i2c_reg_front #(
   parameter int DATA_MAX = i2c_reg_pkg::DATA_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_command,
   input  logic [6:0]          req_slave_addr,
   input  logic [31:0]         req_reg_addr,
   input  logic [2:0]          req_reg_bytes,
   input  logic [5:0]          req_data_count,
   input  logic [7:0]          req_write_byte,
   input  logic                req_sda_in,
   output i2c_reg_pkg::op_type op_out,
   output logic                op_valid,
   input  logic                op_take
);
   import i2c_reg_pkg::*;
   localparam logic [8:0] DMAX = 9'(DATA_MAX);

   op_type     q_ff [FIFO_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     op_new;
   logic       push_ok;

   always_comb begin
      op_new.cmd        = req_command;
      op_new.slave_addr = req_slave_addr;
      op_new.reg_addr   = req_reg_addr;
      op_new.reg_bytes  = (req_reg_bytes > 3'd4) ? 3'd4 : req_reg_bytes;
      op_new.data_count = ({3'b0, req_data_count} > DMAX) ? DMAX : {3'b0, req_data_count};
      op_new.write_byte = req_write_byte;
      op_new.sda_in     = req_sda_in;
   end

   assign req_full = (cnt_ff == 2'(FIFO_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign op_valid = (cnt_ff != 2'd0);
   assign op_out   = q_ff[rp_ff];

   always_comb begin
      wp_in  = push_ok ? ~wp_ff : wp_ff;
      rp_in  = (op_take && op_valid) ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(op_take && op_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wp_ff] <= op_new;
      end
   end
endmodule

>>> sv/i2c_reg_engine.sv
// Back part: the bus phase engine, the transmit buffer and the result queue.
// Depends on i2c_reg_pkg and i2c_reg_ram.
`timescale 1ns / 1ps
module i2c_reg_engine #(
   parameter int DATA_MAX = i2c_reg_pkg::DATA_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  i2c_reg_pkg::op_type op_in,
   input  logic                op_valid,
   output logic                op_take,
   input  logic [15:0]         half_period,
   input  logic [7:0]          ack_timeout,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output i2c_reg_pkg::rsp_type rsp_out
);
   import i2c_reg_pkg::*;
   localparam int AW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
   localparam logic [8:0] DMAX = 9'(DATA_MAX);

   localparam logic [3:0] P_IDLE = 4'd0, P_RS_LOW = 4'd1, P_ST_A = 4'd2, P_ST_B = 4'd3,
      P_WB_LOW = 4'd4, P_WB_HIGH = 4'd5, P_ACK_LOW = 4'd6, P_ACK_POLL = 4'd7,
      P_ACK_HOLD = 4'd8, P_RB_LOW = 4'd9, P_RB_HIGH = 4'd10, P_MA_LOW = 4'd11,
      P_MA_HIGH = 4'd12, P_SP_A = 4'd13, P_SP_B = 4'd14;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [8:0]  byte_ff, byte_in;
   logic [7:0]  wait_ff, wait_in;
   logic [31:0] regs_ff, regs_in;
   logic [8:0]  load_ff, load_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  seg_ff, seg_in;
   logic [2:0]  nreg_ff, nreg_in;
   logic [8:0]  ndata_ff, ndata_in;
   logic [6:0]  taddr_ff, taddr_in;
   logic        err_ff, err_in;
   logic [7:0]  rx_ff, rx_in;
   logic        pend_ff, pend_in;
   rsp_type     res;
   logic        valid, done, aerr;

   // Buffer read address runs one byte ahead so the registered read is ready.
   logic          buf_we;
   logic [AW-1:0] buf_wa, buf_ra;
   logic [7:0]    buf_rd;
   logic [8:0]    pf_ff, pf_in;

   i2c_reg_ram #(.WIDTH(8), .DEPTH(DATA_MAX)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(op_in.write_byte),
      .rd_addr(buf_ra), .rd_data(buf_rd)
   );

   // Result queue of two entries.
   rsp_type    rq_ff [2];
   logic       rw_ff, rr_ff;
   logic [1:0] rc_ff;
   logic       rq_push, rq_pop;

   assign rsp_empty = (rc_ff == 2'd0);
   assign rsp_out   = rq_ff[rr_ff];
   assign rq_pop    = rsp_pop && !rsp_empty;
   // Accept while a slot is free now or frees this cycle.
   assign op_take   = op_valid && ((rc_ff != 2'd2) || rq_pop);
   assign rq_push   = op_take;

   logic [15:0] tick_nx;
   logic        timed;
   logic [15:0] hp;
   logic [7:0]  at, wait_nx;
   logic [8:0]  bidx_nx;
   logic        ma_bit;

   always_comb begin
      hp      = (half_period == 16'd0) ? 16'd1 : half_period;
      at      = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
      tick_nx = tick_ff + 16'd1;
      timed   = (tick_nx >= hp);
      phase_in = phase_ff; tick_in = tick_ff; bit_in = bit_ff; shift_in = shift_ff;
      byte_in = byte_ff; wait_in = wait_ff; regs_in = regs_ff; load_in = load_ff;
      kind_in = kind_ff; seg_in = seg_ff; nreg_in = nreg_ff; ndata_in = ndata_ff;
      taddr_in = taddr_ff; err_in = err_ff; rx_in = rx_ff; pend_in = pend_ff;
      pf_in = pf_ff;
      valid = 1'b0; done = 1'b0; aerr = 1'b0;
      buf_we = 1'b0;
      buf_wa = load_ff[AW-1:0];
      buf_ra = pf_ff[AW-1:0];
      wait_nx = wait_ff + 8'd1;
      bidx_nx = byte_ff + 9'd1;
      if (op_take) begin
         case (op_in.cmd)
            CMD_LOAD: begin
               if (phase_ff == P_IDLE && load_ff < DMAX) begin
                  buf_we  = 1'b1;
                  load_in = load_ff + 9'd1;
               end
            end
            CMD_WRITE, CMD_READ, CMD_PROBE: begin
               if (phase_ff == P_IDLE) begin
                  kind_in  = (op_in.cmd == CMD_WRITE) ? K_WRITE :
                             (op_in.cmd == CMD_READ) ? K_READ : K_PROBE;
                  taddr_in = op_in.slave_addr;
                  nreg_in  = op_in.reg_bytes;
                  ndata_in = op_in.data_count;
                  case (op_in.reg_bytes)
                     3'd1: regs_in = {op_in.reg_addr[7:0], 24'd0};
                     3'd2: regs_in = {op_in.reg_addr[15:0], 16'd0};
                     3'd3: regs_in = {op_in.reg_addr[23:0], 8'd0};
                     3'd4: regs_in = op_in.reg_addr;
                     default: regs_in = 32'd0;
                  endcase
                  seg_in   = (op_in.cmd == CMD_PROBE) ? S_ADDRR : S_ADDRW;
                  byte_in = 9'd0; bit_in = 4'd0; shift_in = 8'd0; wait_in = 8'd0;
                  err_in = 1'b0; tick_in = 16'd0; phase_in = P_ST_A;
                  pf_in = 9'd0;
                  if (op_in.cmd == CMD_WRITE) begin
                     load_in = 9'd0;
                  end
               end
            end
            CMD_TICK: begin
               case (phase_ff)
                  P_RS_LOW, P_ST_A, P_WB_LOW, P_ACK_LOW, P_RB_LOW, P_MA_LOW, P_SP_A: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        case (phase_ff)
                           P_RS_LOW:  phase_in = P_ST_A;
                           P_ST_A:    phase_in = P_ST_B;
                           P_WB_LOW:  phase_in = P_WB_HIGH;
                           P_ACK_LOW: phase_in = P_ACK_POLL;
                           P_RB_LOW:  phase_in = P_RB_HIGH;
                           P_MA_LOW:  phase_in = P_MA_HIGH;
                           default:   phase_in = P_SP_B;
                        endcase
                     end
                  end
                  P_ST_B: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        shift_in = {taddr_ff, (seg_ff == S_ADDRR)};
                        bit_in = 4'd0; phase_in = P_WB_LOW;
                     end
                  end
                  P_WB_HIGH: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in = bit_ff + 4'd1;
                        if (bit_ff == 4'd7) begin
                           wait_in = 8'd0; phase_in = P_ACK_LOW;
                        end else begin
                           phase_in = P_WB_LOW;
                        end
                     end
                  end
                  P_ACK_POLL: begin
                     tick_in = 16'd0;
                     if (!op_in.sda_in) begin
                        phase_in = P_ACK_HOLD;
                     end else begin
                        wait_in = wait_nx;
                        if (wait_nx >= at) begin
                           err_in = 1'b1; phase_in = P_SP_A;
                        end
                     end
                  end
                  P_ACK_HOLD: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        tick_in = 16'd0;
                        if (seg_ff == S_ADDRW || seg_ff == S_REG) begin
                           if (seg_ff == S_ADDRW) byte_in = 9'd0;
                           if (seg_ff == S_REG && byte_ff < {6'd0, nreg_ff} ||
                               seg_ff == S_ADDRW && nreg_ff != 3'd0) begin
                              seg_in = S_REG;
                              shift_in = regs_ff[31:24]; regs_in = {regs_ff[23:0], 8'd0};
                              byte_in = (seg_ff == S_ADDRW) ? 9'd1 : bidx_nx;
                              bit_in = 4'd0; phase_in = P_WB_LOW;
                           end else if (kind_ff == K_WRITE) begin
                              seg_in = S_DATA;
                              if (ndata_ff != 9'd0) begin
                                 shift_in = buf_rd; byte_in = 9'd1; pf_in = 9'd1;
                                 bit_in = 4'd0; phase_in = P_WB_LOW;
                              end else begin
                                 phase_in = P_SP_A;
                              end
                           end else begin
                              seg_in = S_ADDRR; phase_in = P_RS_LOW;
                           end
                        end else if (seg_ff == S_DATA) begin
                           if (byte_ff < ndata_ff) begin
                              shift_in = buf_rd; byte_in = bidx_nx; pf_in = bidx_nx;
                              bit_in = 4'd0; phase_in = P_WB_LOW;
                           end else begin
                              phase_in = P_SP_A;
                           end
                        end else if (seg_ff == S_ADDRR && kind_ff != K_PROBE &&
                                     ndata_ff != 9'd0) begin
                           seg_in = S_READ; byte_in = 9'd0; bit_in = 4'd0;
                           shift_in = 8'd0; phase_in = P_RB_LOW;
                        end else begin
                           phase_in = P_SP_A;
                        end
                     end
                  end
                  P_RB_HIGH: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        shift_in = {shift_ff[6:0], op_in.sda_in};
                        bit_in = bit_ff + 4'd1;
                        if (bit_ff == 4'd7) begin
                           rx_in = {shift_ff[6:0], op_in.sda_in};
                           valid = 1'b1; phase_in = P_MA_LOW;
                        end else begin
                           phase_in = P_RB_LOW;
                        end
                     end
                  end
                  P_MA_HIGH: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        byte_in = bidx_nx;
                        if (bidx_nx < ndata_ff) begin
                           bit_in = 4'd0; shift_in = 8'd0; phase_in = P_RB_LOW;
                        end else begin
                           phase_in = P_SP_A;
                        end
                     end
                  end
                  P_SP_B: begin
                     tick_in = timed ? 16'd0 : tick_nx;
                     if (timed) begin
                        phase_in = P_IDLE; done = 1'b1; aerr = err_ff; err_in = 1'b0;
                     end
                  end
                  default: phase_in = P_IDLE;
               endcase
            end
            default: ;
         endcase
      end
      if (phase_in == P_WB_LOW || phase_in == P_ACK_HOLD || phase_in == P_ACK_LOW ||
          phase_in == P_ACK_POLL || phase_in == P_WB_HIGH) begin
         buf_ra = pf_in[AW-1:0];
      end else begin
         buf_ra = pf_in[AW-1:0];
      end
      pend_in = 1'b0;
      ma_bit = (byte_in + 9'd1 < ndata_in) ? 1'b0 : 1'b1;
      case (phase_in)
         P_RS_LOW:  begin res.scl_out = 1'b0; res.sda_out = 1'b1; end
         P_ST_B:    begin res.scl_out = 1'b1; res.sda_out = 1'b0; end
         P_WB_LOW:  begin res.scl_out = 1'b0; res.sda_out = shift_in[7]; end
         P_WB_HIGH: begin res.scl_out = 1'b1; res.sda_out = shift_in[7]; end
         P_ACK_LOW, P_RB_LOW: begin res.scl_out = 1'b0; res.sda_out = 1'b1; end
         P_MA_LOW:  begin res.scl_out = 1'b0; res.sda_out = ma_bit; end
         P_MA_HIGH: begin res.scl_out = 1'b1; res.sda_out = ma_bit; end
         P_SP_A:    begin res.scl_out = 1'b0; res.sda_out = 1'b0; end
         P_SP_B:    begin res.scl_out = 1'b1; res.sda_out = 1'b0; end
         default:   begin res.scl_out = 1'b1; res.sda_out = 1'b1; end
      endcase
      res.read_data  = rx_in;
      res.read_valid = valid;
      res.busy_res   = (phase_in != P_IDLE);
      res.done_res   = done;
      res.ack_error  = aerr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; tick_ff <= '0; bit_ff <= '0; shift_ff <= '0; byte_ff <= '0;
         wait_ff <= '0; regs_ff <= '0; load_ff <= '0; kind_ff <= K_WRITE; seg_ff <= S_ADDRW;
         nreg_ff <= '0; ndata_ff <= '0; taddr_ff <= '0; err_ff <= 1'b0; rx_ff <= '0;
         pend_ff <= 1'b0; pf_ff <= '0;
         rw_ff <= 1'b0; rr_ff <= 1'b0; rc_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in; tick_ff <= tick_in; bit_ff <= bit_in; shift_ff <= shift_in;
         byte_ff <= byte_in; wait_ff <= wait_in; regs_ff <= regs_in; load_ff <= load_in;
         kind_ff <= kind_in; seg_ff <= seg_in; nreg_ff <= nreg_in; ndata_ff <= ndata_in;
         taddr_ff <= taddr_in; err_ff <= err_in; rx_ff <= rx_in; pend_ff <= pend_in;
         pf_ff <= pf_in;
         if (rq_push) rw_ff <= ~rw_ff;
         if (rq_pop) rr_ff <= ~rr_ff;
         rc_ff <= rc_ff + 2'(rq_push) - 2'(rq_pop);
      end
      if (rq_push) begin
         rq_ff[rw_ff] <= res;
      end
   end
endmodule

>>> sv/i2c_reg_checker.sv
// Port-level checks for the I2C register master, bound to the top level.
// Depends on i2c_register_master_core.
`timescale 1ns / 1ps
module i2c_reg_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_busy_res,
   input logic rsp_done_res,
   input logic rsp_ack_error,
   input logic rsp_read_valid
);
   // An error is only reported with the stop that ends a transaction.
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_ack_error |-> rsp_done_res)
      else $error("ack_error without done");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_done_res |-> !rsp_busy_res)
      else $error("done while busy");
   a_rv_busy: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_read_valid |-> rsp_busy_res)
      else $error("read byte outside a transaction");
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result lost");
endmodule

bind i2c_register_master_core i2c_reg_checker u_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_busy_res(rsp_busy_res),
   .rsp_done_res(rsp_done_res), .rsp_ack_error(rsp_ack_error),
   .rsp_read_valid(rsp_read_valid)
);

>>> tb/tb.sv
// Self-checking testbench for i2c_register_master_core: drives request transactions,
// predicts every result transaction in-line and compares them field by field.
// Depends on i2c_reg_pkg and the core with its submodules.
`timescale 1ns / 1ps
module tb;
   import i2c_reg_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_RS_LOW, PH_ST_A, PH_ST_B, PH_WB_LOW, PH_WB_HIGH, PH_ACK_LOW,
      PH_ACK_POLL, PH_ACK_HOLD, PH_RB_LOW, PH_RB_HIGH, PH_MA_LOW, PH_MA_HIGH,
      PH_SP_A, PH_SP_B
   } bus_phase_e;

   typedef struct packed {
      logic [2:0]  command;
      logic [6:0]  slave_addr;
      logic [31:0] reg_addr;
      logic [2:0]  reg_bytes;
      logic [5:0]  data_count;
      logic [7:0]  write_byte;
      logic        sda_in;
   } bus_req_t;

   localparam int BUF_DEPTH = DATA_MAX_DEF;

   logic        clock, reset;
   logic        req_push, req_full;
   logic [2:0]  req_command;
   logic [6:0]  req_slave_addr;
   logic [31:0] req_reg_addr;
   logic [2:0]  req_reg_bytes;
   logic [5:0]  req_data_count;
   logic [7:0]  req_write_byte;
   logic        req_sda_in;
   logic        rsp_empty, rsp_pop;
   logic        rsp_scl_out, rsp_sda_out;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid, rsp_busy_res, rsp_done_res, rsp_ack_error;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;

   i2c_register_master_core dut (.*);

   // Model of the bus engine.
   logic [15:0] m_half;
   logic [7:0]  m_tmo;
   bus_phase_e  m_ph;
   logic [15:0] m_tcnt;
   int unsigned m_bit, m_byte, m_load, m_nreg, m_ndata, m_loaded_max;
   logic [7:0]  m_ackw, m_shift, m_last_rx;
   logic [31:0] m_regsh;
   logic [7:0]  m_txbuf [BUF_DEPTH];
   logic [1:0]  m_kind;
   logic [2:0]  m_seg;
   logic [6:0]  m_taddr;
   bit          m_err;

   rsp_type     bus_rsp_q[$];
   int          errors = 0;
   int          items_sent = 0;
   int          send_idle = 0, recv_idle = 0;

   function automatic bit count_done();
      m_tcnt = m_tcnt + 16'd1;
      if (m_tcnt >= m_half) begin
         m_tcnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void shift_out(logic [7:0] b);
      m_shift = b;
      m_bit = 0;
      m_tcnt = '0;
      m_ph = PH_WB_LOW;
   endfunction

   function automatic void to_stop();
      m_tcnt = '0;
      m_ph = PH_SP_A;
   endfunction

   function automatic void next_after_ack();
      if (m_seg == S_ADDRW) begin
         m_seg = S_REG;
         m_byte = 0;
      end
      if (m_seg == S_REG) begin
         if (m_byte < m_nreg) begin
            shift_out(m_regsh[31:24]);
            m_regsh = m_regsh << 8;
            m_byte++;
            return;
         end
         if (m_kind == K_WRITE) begin
            m_seg = S_DATA;
            m_byte = 0;
         end else begin
            m_seg = S_ADDRR;
            m_tcnt = '0;
            m_ph = PH_RS_LOW;
            return;
         end
      end
      if (m_seg == S_DATA) begin
         if (m_byte < m_ndata && m_byte < BUF_DEPTH) begin
            shift_out(m_txbuf[m_byte]);
            m_byte++;
         end else begin
            to_stop();
         end
         return;
      end
      if (m_seg == S_ADDRR && m_kind != K_PROBE && m_ndata != 0) begin
         m_seg = S_READ;
         m_byte = 0;
         m_bit = 0;
         m_shift = '0;
         m_tcnt = '0;
         m_ph = PH_RB_LOW;
         return;
      end
      to_stop();
   endfunction

   function automatic rsp_type predict_bus(bus_req_t it);
      rsp_type r;
      logic    ma;
      r = '0;
      case (it.command)
         CMD_LOAD: begin
            if (m_ph == PH_IDLE && m_load < BUF_DEPTH) begin
               m_txbuf[m_load] = it.write_byte;
               m_load++;
               if (m_load > m_loaded_max) m_loaded_max = m_load;
            end
         end
         CMD_WRITE, CMD_READ, CMD_PROBE: begin
            if (m_ph == PH_IDLE) begin
               m_kind = (it.command == CMD_WRITE) ? K_WRITE :
                        (it.command == CMD_READ) ? K_READ : K_PROBE;
               m_taddr = it.slave_addr;
               m_nreg = (it.reg_bytes > 3'd4) ? 4 : it.reg_bytes;
               m_ndata = (it.data_count > 6'd32) ? 32 : it.data_count;
               m_regsh = (m_nreg == 0) ? '0 : it.reg_addr << ((4 - m_nreg) * 8);
               m_seg = (m_kind == K_PROBE) ? S_ADDRR : S_ADDRW;
               m_byte = 0;
               m_bit = 0;
               m_shift = '0;
               m_ackw = '0;
               m_err = 1'b0;
               m_tcnt = '0;
               m_ph = PH_ST_A;
               if (m_kind == K_WRITE) m_load = 0;
            end
         end
         CMD_TICK: begin
            case (m_ph)
               PH_RS_LOW:  if (count_done()) m_ph = PH_ST_A;
               PH_ST_A:    if (count_done()) m_ph = PH_ST_B;
               PH_ST_B:    if (count_done())
                              shift_out({m_taddr, m_seg == S_ADDRR});
               PH_WB_LOW:  if (count_done()) m_ph = PH_WB_HIGH;
               PH_WB_HIGH: if (count_done()) begin
                  m_shift = m_shift << 1;
                  m_bit++;
                  if (m_bit >= 8) begin
                     m_ackw = '0;
                     m_ph = PH_ACK_LOW;
                  end else begin
                     m_ph = PH_WB_LOW;
                  end
               end
               PH_ACK_LOW: if (count_done()) m_ph = PH_ACK_POLL;
               PH_ACK_POLL: begin
                  m_tcnt = '0;
                  if (!it.sda_in) begin
                     m_ph = PH_ACK_HOLD;
                  end else begin
                     m_ackw = m_ackw + 8'd1;
                     if (m_ackw >= m_tmo) begin
                        m_err = 1'b1;
                        to_stop();
                     end
                  end
               end
               PH_ACK_HOLD: if (count_done()) next_after_ack();
               PH_RB_LOW:   if (count_done()) m_ph = PH_RB_HIGH;
               PH_RB_HIGH:  if (count_done()) begin
                  m_shift = {m_shift[6:0], it.sda_in};
                  m_bit++;
                  if (m_bit >= 8) begin
                     m_last_rx = m_shift;
                     r.read_valid = 1'b1;
                     m_ph = PH_MA_LOW;
                  end else begin
                     m_ph = PH_RB_LOW;
                  end
               end
               PH_MA_LOW:  if (count_done()) m_ph = PH_MA_HIGH;
               PH_MA_HIGH: if (count_done()) begin
                  m_byte++;
                  if (m_byte < m_ndata) begin
                     m_bit = 0;
                     m_shift = '0;
                     m_ph = PH_RB_LOW;
                  end else begin
                     to_stop();
                  end
               end
               PH_SP_A: if (count_done()) m_ph = PH_SP_B;
               PH_SP_B: if (count_done()) begin
                  m_ph = PH_IDLE;
                  r.done_res = 1'b1;
                  r.ack_error = m_err;
                  m_err = 1'b0;
               end
               default: m_ph = PH_IDLE;
            endcase
         end
         default: ;
      endcase
      ma = (m_byte + 1 < m_ndata) ? 1'b0 : 1'b1;
      case (m_ph)
         PH_RS_LOW, PH_ACK_LOW, PH_RB_LOW: {r.scl_out, r.sda_out} = 2'b01;
         PH_ST_B:    {r.scl_out, r.sda_out} = 2'b10;
         PH_WB_LOW:  {r.scl_out, r.sda_out} = {1'b0, m_shift[7]};
         PH_WB_HIGH: {r.scl_out, r.sda_out} = {1'b1, m_shift[7]};
         PH_MA_LOW:  {r.scl_out, r.sda_out} = {1'b0, ma};
         PH_MA_HIGH: {r.scl_out, r.sda_out} = {1'b1, ma};
         PH_SP_A:    {r.scl_out, r.sda_out} = 2'b00;
         PH_SP_B:    {r.scl_out, r.sda_out} = 2'b10;
         default:    {r.scl_out, r.sda_out} = 2'b11;
      endcase
      r.read_data = m_last_rx;
      r.busy_res = (m_ph != PH_IDLE);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: random pop pressure and in-order comparison.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bus_rsp_q.size() == 0) begin
               $display("%0t: unexpected result transaction", $time);
               errors++;
            end else begin
               want = bus_rsp_q.pop_front();
               if (want !== {rsp_scl_out, rsp_sda_out, rsp_read_data, rsp_read_valid,
                             rsp_busy_res, rsp_done_res, rsp_ack_error}) begin
                  $display("%0t: mismatch scl/sda/data/valid/busy/done/err expected %b %b %h %b %b %b %b actual %b %b %h %b %b %b %b",
                           $time, want.scl_out, want.sda_out, want.read_data,
                           want.read_valid, want.busy_res, want.done_res, want.ack_error,
                           rsp_scl_out, rsp_sda_out, rsp_read_data, rsp_read_valid,
                           rsp_busy_res, rsp_done_res, rsp_ack_error);
                  errors++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_req(bus_req_t it);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      {req_command, req_slave_addr, req_reg_addr, req_reg_bytes, req_data_count,
       req_write_byte, req_sda_in} <= it;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      bus_rsp_q.push_back(predict_bus(it));
      items_sent++;
   endtask

   function automatic bus_req_t rand_req(logic [2:0] cmd);
      bus_req_t it;
      it.command = cmd;
      it.slave_addr = $urandom_range(127);
      it.reg_addr = $urandom;
      it.reg_bytes = $urandom_range(7);
      it.data_count = $urandom_range(63);
      it.write_byte = $urandom_range(255);
      it.sda_in = $urandom_range(1);
      return it;
   endfunction

   task automatic send_tick(int ack_low_pct);
      bus_req_t it;
      it = rand_req(CMD_TICK);
      if (m_ph == PH_ACK_POLL) it.sda_in = ($urandom_range(99) >= ack_low_pct);
      send_req(it);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (bus_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_HALF_PERIOD) m_half = val;
      else m_tmo = val[7:0];
   endtask

   // One transaction on the bus: loads, a start and ticks until stop.
   // Noise (loads, starts and unknown codes while busy) is mixed in.
   task automatic bus_transfer(logic [2:0] cmd, int loads, logic [5:0] dc,
                               int noise_pct, int ack_low_pct);
      bus_req_t it;
      int       eff;
      for (int i = 0; i < loads; i++) send_req(rand_req(CMD_LOAD));
      it = rand_req(cmd);
      it.data_count = dc;
      if (cmd == CMD_WRITE) begin
         // Never send a buffer entry that has not been written.
         eff = (dc > 6'd32) ? 32 : dc;
         if (eff > m_loaded_max) it.data_count = m_loaded_max;
      end
      send_req(it);
      while (m_ph != PH_IDLE) begin
         if ($urandom_range(99) < noise_pct)
            send_req(rand_req($urandom_range(1, 7)));
         else
            send_tick(ack_low_pct);
      end
   endtask

   task automatic test_directed();
      bus_req_t it;
      send_tick(0);
      send_req(rand_req(3'd5));
      send_req(rand_req(3'd7));
      it = rand_req(CMD_LOAD); it.write_byte = 8'h00; send_req(it);
      it = rand_req(CMD_LOAD); it.write_byte = 8'hFF; send_req(it);
      it = rand_req(CMD_WRITE);
      it.slave_addr = 7'h7F; it.reg_addr = 32'hFFFF_FFFF; it.reg_bytes = 3'd4;
      it.data_count = 6'd2;
      send_req(it);
      // A start while busy is dropped, as is a load.
      send_req(rand_req(CMD_READ));
      send_req(rand_req(CMD_LOAD));
      while (m_ph != PH_IDLE) send_tick(100);
      bus_transfer(CMD_READ, 0, 6'd0, 0, 100);
      bus_transfer(CMD_READ, 0, 6'd2, 0, 100);
      bus_transfer(CMD_WRITE, 0, 6'd0, 0, 100);
   endtask

   task automatic test_config_extremes();
      // Probes with no device, where every ack poll sees SDA high, then one that is acked.
      write_csr(CSR_HALF_PERIOD, 16'd1);
      write_csr(CSR_ACK_TIMEOUT, 16'd1);
      bus_transfer(CMD_PROBE, 0, 6'd0, 0, 0);
      write_csr(CSR_ACK_TIMEOUT, 16'd0);
      bus_transfer(CMD_PROBE, 0, 6'd0, 0, 0);
      write_csr(CSR_HALF_PERIOD, 16'd0);
      write_csr(CSR_ACK_TIMEOUT, 16'd255);
      bus_transfer(CMD_PROBE, 0, 6'd0, 0, 100);
      // With the slowest divider only six loads and four ticks are sent while idle.
      write_csr(CSR_HALF_PERIOD, 16'hFFFF);
      for (int i = 0; i < 6; i++) send_req(rand_req(CMD_LOAD));
      for (int i = 0; i < 4; i++) send_tick(50);
      write_csr(CSR_HALF_PERIOD, 16'd1);
      // Overfill the buffer, then a full-length write.
      bus_transfer(CMD_WRITE, 34, 6'd63, 0, 100);
   endtask

   task automatic test_random(int budget);
      int       target;
      int       k;
      logic [5:0] dc;
      target = items_sent + budget;
      while (items_sent < target) begin
         if ($urandom_range(99) < 12) begin
            write_csr(CSR_HALF_PERIOD, $urandom_range(0, 3));
            k = $urandom_range(3);
            write_csr(CSR_ACK_TIMEOUT, (k == 0) ? 255 : $urandom_range(0, 4));
         end
         dc = ($urandom_range(99) < 5) ? $urandom_range(63) : $urandom_range(3);
         k = $urandom_range(2);
         bus_transfer((k == 0) ? CMD_WRITE : (k == 1) ? CMD_READ : CMD_PROBE,
                      $urandom_range(0, 4), dc, 4, 85);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      {req_command, req_slave_addr, req_reg_addr, req_reg_bytes, req_data_count,
       req_write_byte, req_sda_in} = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      m_half = 16'd5; m_tmo = 8'd255; m_ph = PH_IDLE; m_tcnt = '0;
      m_bit = 0; m_byte = 0; m_load = 0; m_nreg = 0; m_ndata = 0; m_loaded_max = 0;
      m_ackw = '0; m_shift = '0; m_last_rx = '0; m_regsh = '0;
      m_kind = K_WRITE; m_seg = S_ADDRW; m_taddr = '0; m_err = 1'b0;
      foreach (m_txbuf[i]) m_txbuf[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 27; recv_idle = 61;
      test_directed();
      test_config_extremes();
      test_random(240);
      send_idle = 61; recv_idle = 27;
      test_random(240);
      send_idle = 0; recv_idle = 0;
      test_random(240);
      drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
